### src/stl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants of the session table
// Kinds, status codes and sizes used by the front, back and top level.
// ----------------------------------------------------------------------------
package stl_pkg;
    localparam int TableEntriesDefault = 64;
    localparam int IdW    = 64;
    localparam int SeqW   = 64;
    localparam int StampW = 64;
    localparam int SlotW  = 6;
    localparam int EvW    = 32;

    typedef enum logic [1:0] {
        K_OBSERVE = 2'd0,
        K_CREATE  = 2'd1,
        K_LOOKUP  = 2'd2,
        K_TOUCH   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_DONE     = 2'd0,
        S_NOTFOUND = 2'd1,
        S_REJECTED = 2'd2
    } t_status;

    typedef struct packed {
        t_kind           kind;
        logic [IdW-1:0]  session_id;
        logic [SeqW-1:0] seq_no;
    } t_req;

    typedef struct packed {
        t_status         status;
        logic [SlotW-1:0] slot;
        logic [SeqW-1:0] last_seq;
        logic            did_evict;
        logic [EvW-1:0]  evict_total;
    } t_rsp;
endpackage
`default_nettype wire

### src/stl_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_req_if / stl_rsp_if: valid-ready channels of the session table
// Request and response channels with source and sink modports.
// ----------------------------------------------------------------------------
interface stl_req_if
    import stl_pkg::*;
;
    logic valid;
    logic ready;
    t_kind           kind;
    logic [IdW-1:0]  session_id;
    logic [SeqW-1:0] seq_no;
    modport source (output valid, kind, session_id, seq_no, input ready);
    modport sink   (input valid, kind, session_id, seq_no, output ready);
endinterface

interface stl_rsp_if
    import stl_pkg::*;
;
    logic valid;
    logic ready;
    t_status          status;
    logic [SlotW-1:0] slot;
    logic [SeqW-1:0]  last_seq;
    logic             did_evict;
    logic [EvW-1:0]   evict_total;
    modport source (output valid, status, slot, last_seq, did_evict, evict_total,
                    input ready);
    modport sink   (input valid, status, slot, last_seq, did_evict, evict_total,
                    output ready);
endinterface
`default_nettype wire

### src/stl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_front: request intake and queue
// Takes requests and holds up to two in a small queue for the back end.
// ----------------------------------------------------------------------------
module stl_front
    import stl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_req      o_req
);
    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### src/stl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_back: table scan and update engine
// Scans the table one slot a cycle for the id and the oldest stamp,
// then applies the request and presents one response.
// ----------------------------------------------------------------------------
module stl_back
    import stl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDefault
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_rsp      o_rsp
);
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] Full = CW'(TABLE_ENTRIES);

    typedef enum logic [2:0] {ST_IDLE, ST_ISSUE, ST_SCAN, ST_APPLY, ST_OUT} t_state;

    logic [IdW-1:0]    m_id    [TABLE_ENTRIES];
    logic [StampW-1:0] m_stamp [TABLE_ENTRIES];
    logic [SeqW-1:0]   m_seq   [TABLE_ENTRIES];

    t_state            r_st;
    t_req              r_req;
    logic [CW-1:0]     r_used;
    logic [StampW-1:0] r_ctr;
    logic [EvW-1:0]    r_evc;
    logic [CW-1:0]     r_idx;     // slot being read
    logic [CW-1:0]     r_didx;    // slot whose data is in the read registers
    logic              r_dv;
    logic [IdW-1:0]    r_rd_id;
    logic [StampW-1:0] r_rd_stamp;
    logic              r_hit;
    logic [AW-1:0]     r_hslot;
    logic [AW-1:0]     r_lslot;
    logic [StampW-1:0] r_lstamp;
    logic [AW-1:0]     r_kslot;
    logic [SeqW-1:0]   r_rd_seq;
    logic              r_seqv;
    t_rsp              r_rsp;

    logic [AW-1:0]     wa;
    logic              we_id, we_stamp, we_seq;
    logic [IdW-1:0]    wd_id;
    logic [StampW-1:0] wd_stamp;
    logic [SeqW-1:0]   wd_seq;

    assign o_ready = (r_st == ST_IDLE);
    assign o_valid = (r_st == ST_OUT);
    assign o_rsp   = r_rsp;

    // memory ports: one read, one write per array
    always_ff @(posedge i_clk) begin
        if (we_id)    m_id[wa]    <= wd_id;
        if (we_stamp) m_stamp[wa] <= wd_stamp;
        if (we_seq)   m_seq[wa]   <= wd_seq;
        r_rd_id    <= m_id[r_idx[AW-1:0]];
        r_rd_stamp <= m_stamp[r_idx[AW-1:0]];
        r_rd_seq   <= m_seq[r_kslot];
    end

    // apply step decisions
    logic          is_new, do_ins, ok;
    logic [AW-1:0] k;
    logic          full;
    logic [SeqW-1:0] newseq;
    always_comb begin
        full   = (r_used == Full);
        is_new = 1'b0;
        do_ins = 1'b0;
        ok     = 1'b0;
        case (r_req.kind)
            K_OBSERVE: begin
                ok = (r_req.session_id != '0);
                do_ins = ok && !r_hit;
            end
            K_CREATE: begin
                ok = (r_req.session_id != '0) && !r_hit;
                do_ins = ok;
            end
            K_LOOKUP, K_TOUCH: ok = r_hit;
            default: ok = 1'b0;
        endcase
        is_new = do_ins;
        if (!do_ins)   k = r_hslot;
        else if (full) k = r_lslot;
        else           k = r_used[AW-1:0];
        newseq = (is_new || r_req.seq_no > r_rd_seq) ? r_req.seq_no :
                 r_rd_seq;
        we_id = 1'b0; we_stamp = 1'b0; we_seq = 1'b0;
        wa = k; wd_id = r_req.session_id; wd_seq = '0; wd_stamp = r_ctr;
        if (r_st == ST_APPLY && r_seqv && ok) begin
            case (r_req.kind)
                K_OBSERVE: begin
                    we_id = do_ins; we_seq = 1'b1; we_stamp = 1'b1;
                    wd_seq = newseq;
                    wd_stamp = do_ins ? r_ctr + StampW'(1) : r_ctr;
                end
                K_CREATE: begin
                    we_id = 1'b1; we_seq = 1'b1; we_stamp = 1'b1;
                end
                K_TOUCH: we_stamp = 1'b1;
                default: we_stamp = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_used <= '0;
            r_ctr  <= StampW'(1);
            r_evc  <= '0;
            r_dv   <= 1'b0;
            r_seqv <= 1'b0;
        end else begin
            case (r_st)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_req  <= i_req;
                        r_idx  <= '0;
                        r_dv   <= 1'b0;
                        r_hit  <= 1'b0;
                        r_lslot <= '0;
                        r_st   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // pipelined scan: address in r_idx, data in r_rd_id/r_rd_stamp the cycle after
                    r_dv   <= (r_idx < r_used);
                    r_didx <= r_idx;
                    if (r_idx < r_used) r_idx <= r_idx + CW'(1);
                    if (r_dv) begin
                        if (!r_hit && r_rd_id == r_req.session_id
                            && r_req.session_id != '0) begin
                            r_hit   <= 1'b1;
                            r_hslot <= r_didx[AW-1:0];
                        end
                        if (r_didx == '0 || r_rd_stamp < r_lstamp) begin
                            r_lstamp <= r_rd_stamp;
                            r_lslot  <= r_didx[AW-1:0];
                        end
                    end else if (!(r_idx < r_used)) begin
                        r_st   <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    r_kslot <= k;
                    r_seqv  <= 1'b0;
                    r_st    <= ST_APPLY;
                end
                ST_APPLY: begin
                    if (!r_seqv) begin
                        r_seqv <= 1'b1;   // seq of slot k now in r_rd_seq
                    end else begin
                        r_seqv <= 1'b0;
                        r_rsp.status    <= ok ? S_DONE :
                            ((r_req.kind == K_LOOKUP || r_req.kind == K_TOUCH) ?
                             S_NOTFOUND : S_REJECTED);
                        r_rsp.slot      <= ok ? SlotW'(k) : '0;
                        r_rsp.did_evict <= ok && do_ins && full;
                        r_rsp.evict_total <= (ok && do_ins && full && r_evc != '1) ?
                                             r_evc + EvW'(1) : r_evc;
                        if (!ok) r_rsp.last_seq <= '0;
                        else if (r_req.kind == K_OBSERVE) r_rsp.last_seq <= newseq;
                        else if (r_req.kind == K_CREATE) r_rsp.last_seq <= '0;
                        else r_rsp.last_seq <= r_rd_seq;
                        if (ok && do_ins && full && r_evc != '1) r_evc <= r_evc + EvW'(1);
                        if (ok && do_ins && !full) r_used <= r_used + CW'(1);
                        if (ok) begin
                            case (r_req.kind)
                                K_OBSERVE: r_ctr <= r_ctr + (do_ins ? StampW'(2) : StampW'(1));
                                K_CREATE, K_TOUCH: r_ctr <= r_ctr + StampW'(1);
                                default: r_ctr <= r_ctr;
                            endcase
                        end
                        r_st <= ST_OUT;
                    end
                end
                ST_OUT: if (i_ready) r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### src/session_table_lru.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// session_table_lru: session table with least-recently-seen replacement
// Observe, create, lookup and touch requests against a table of sessions.
// ----------------------------------------------------------------------------
// Each request gives one response. A two-entry queue takes requests while
// the back end works; the back end reads the table one slot a cycle to find
// the id and, in the same pass, the oldest stamp. A request passes the back
// end's states in order: idle takes it, scan reads the used slots, issue
// addresses the sequence of the chosen slot, apply reads it and updates the
// table, and out presents the response until it is taken.
// The scan length is set by the single read port of the table memories. No
// clearing pass is needed: only data from slots below the fill count is used.
// ----------------------------------------------------------------------------
module session_table_lru
    import stl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDefault
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    stl_req_if.sink   i_req,
    stl_rsp_if.source o_rsp
);
    t_req in_req, q_req;
    t_rsp rsp;
    logic q_valid, q_ready;

    // pack the request fields
    assign in_req.kind       = i_req.kind;
    assign in_req.session_id = i_req.session_id;
    assign in_req.seq_no     = i_req.seq_no;

    stl_front u_front (
        .i_clk, .i_rst_n,
        .i_valid (i_req.valid), .o_ready (i_req.ready), .i_req (in_req),
        .o_valid (q_valid), .i_ready (q_ready), .o_req (q_req)
    );

    stl_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk, .i_rst_n,
        .i_valid (q_valid), .o_ready (q_ready), .i_req (q_req),
        .o_valid (o_rsp.valid), .i_ready (o_rsp.ready), .o_rsp (rsp)
    );

    // response fields from the back end's output register
    assign o_rsp.status      = rsp.status;
    assign o_rsp.slot        = rsp.slot;
    assign o_rsp.last_seq    = rsp.last_seq;
    assign o_rsp.did_evict   = rsp.did_evict;
    assign o_rsp.evict_total = rsp.evict_total;
endmodule
`default_nettype wire

### src/stl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_checker: port-level checks of the session table
// Watches the response channel and binds to the top level.
// ----------------------------------------------------------------------------
module stl_checker
    import stl_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_rv,
    input wire logic             i_rr,
    input wire t_status          i_st,
    input wire logic [SlotW-1:0] i_sl,
    input wire logic [SeqW-1:0]  i_ls,
    input wire logic             i_ev,
    input wire logic [EvW-1:0]   i_et
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rv && !i_rr |=> i_rv && $stable(i_et)) else $error("response dropped");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rv && i_st != S_DONE |-> i_sl == '0 && i_ls == '0 && !i_ev)
        else $error("fields not zero");
    a_evst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rv && i_ev |-> i_et != '0) else $error("evict without count");
    a_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rv && i_rr ##1 i_rv |-> i_et >= $past(i_et, 1)) else $error("count fell");
endmodule

bind session_table_lru stl_checker u_chk (
    .i_clk, .i_rst_n,
    .i_rv (o_rsp.valid), .i_rr (o_rsp.ready), .i_st (o_rsp.status),
    .i_sl (o_rsp.slot), .i_ls (o_rsp.last_seq), .i_ev (o_rsp.did_evict),
    .i_et (o_rsp.evict_total)
);
`default_nettype wire

### tb/tb_session_table_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_session_table_lru: regression bench for the session table
// Directed rows, then random requests over a small id pool so that hits,
// misses, fills and evictions all occur. Every response is checked against
// an in-bench model of the table, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_session_table_lru;
    import stl_pkg::*;

    localparam int Entries  = TableEntriesDefault;
    localparam int NumRand  = 1430;
    localparam int WdogMax  = 20000;
    localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

    logic i_clk;
    logic i_rst_n;

    stl_req_if req_ch ();
    stl_rsp_if rsp_ch ();

    session_table_lru #(.TABLE_ENTRIES(Entries)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---- in-bench model of the table ----
    logic [63:0] tbl_id    [Entries];
    logic [63:0] tbl_stamp [Entries];
    logic [63:0] tbl_seq   [Entries];
    int          tbl_used;
    logic [63:0] stamp_next;
    logic [31:0] evictions;

    t_rsp pending_rsp[$];
    int   err_count;
    bit   drain_mode;       // response side holds off for a long stretch
    bit   stim_done;

    function automatic int find_session(logic [63:0] sid);
        if (sid == '0) return -1;
        for (int i = 0; i < tbl_used; i++)
            if (tbl_id[i] == sid) return i;
        return -1;
    endfunction

    // Takes a slot (evicting the oldest stamp when full) and stamps it once.
    function automatic int claim_slot(logic [63:0] sid, output logic ev);
        int k;
        k = 0;
        if (tbl_used >= Entries) begin
            // first smallest stamp wins a tie
            for (int i = 1; i < Entries; i++)
                if (tbl_stamp[i] < tbl_stamp[k]) k = i;
            if (evictions != 32'hFFFF_FFFF) evictions++;
            ev = 1'b1;
        end else begin
            k = tbl_used;
            tbl_used++;
            ev = 1'b0;
        end
        tbl_id[k]    = sid;
        tbl_seq[k]   = '0;
        tbl_stamp[k] = stamp_next;
        stamp_next++;
        return k;
    endfunction

    function automatic t_rsp apply_request(t_kind kind, logic [63:0] sid,
                                           logic [63:0] cseq);
        t_rsp r;
        int   f;
        int   k;
        logic ev;
        r  = '0;
        ev = 1'b0;
        f  = find_session(sid);
        case (kind)
            K_OBSERVE: begin
                if (sid == '0) begin
                    r.status = S_REJECTED;
                end else begin
                    k = (f < 0) ? claim_slot(sid, ev) : f;
                    if (cseq > tbl_seq[k]) tbl_seq[k] = cseq;
                    tbl_stamp[k] = stamp_next;
                    stamp_next++;
                    r.status    = S_DONE;
                    r.slot      = k[SlotW-1:0];
                    r.last_seq  = tbl_seq[k];
                    r.did_evict = ev;
                end
            end
            K_CREATE: begin
                if (sid == '0 || f >= 0) begin
                    r.status = S_REJECTED;
                end else begin
                    k = claim_slot(sid, ev);
                    r.status    = S_DONE;
                    r.slot      = k[SlotW-1:0];
                    r.last_seq  = tbl_seq[k];
                    r.did_evict = ev;
                end
            end
            default: begin
                if (f < 0) begin
                    r.status = S_NOTFOUND;
                end else begin
                    if (kind == K_TOUCH) begin
                        tbl_stamp[f] = stamp_next;
                        stamp_next++;
                    end
                    r.status   = S_DONE;
                    r.slot     = f[SlotW-1:0];
                    r.last_seq = tbl_seq[f];
                end
            end
        endcase
        r.evict_total = evictions;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // ---- directed table: typed expectations where obvious, else model ----
    typedef struct {
        t_kind       kind;
        logic [63:0] sid;
        logic [63:0] cseq;
        bit          typed;
        t_rsp        want;
    } t_row;

    t_row rows[$];

    function automatic t_rsp mk(t_status st, int sl, logic [63:0] ls);
        t_rsp r;
        r = '0;
        r.status = st;
        r.slot = sl[SlotW-1:0];
        r.last_seq = ls;
        return r;
    endfunction

    task automatic add_row(t_kind k, logic [63:0] s, logic [63:0] q, bit t, t_rsp w);
        t_row r;
        r.kind = k; r.sid = s; r.cseq = q; r.typed = t; r.want = w;
        rows.push_back(r);
    endtask

    function automatic logic [63:0] pick_id();
        // small pool keeps the table busy with hits, misses and evictions
        case ($urandom_range(0, 9))
            0:       return {$urandom, $urandom};
            1:       return '0;
            2:       return AllOnes - 64'($urandom_range(0, 3));
            default: return 64'($urandom_range(1, 90)) << (4 * $urandom_range(0, 15));
        endcase
    endfunction

    function automatic logic [63:0] pick_seq();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return AllOnes;
            2:       return 64'($urandom_range(0, 1000));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_one(t_kind k, logic [63:0] s, logic [63:0] q, bit typed, t_rsp w);
        t_rsp pred;
        pred = apply_request(k, s, q);
        if (typed && pred != w) begin
            // table row disagrees with the model: count it against the row
            report_mismatch("table row", 64'(w), 64'(pred));
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= k;
        req_ch.session_id <= s;
        req_ch.seq_no     <= q;
        pending_rsp.push_back(pred);
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic idle_gap();
        int gap;
        gap = drain_mode ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // ---- stimulus ----
    initial begin
        t_kind k;
        req_ch.valid      = 1'b0;
        req_ch.kind       = K_OBSERVE;
        req_ch.session_id = '0;
        req_ch.seq_no     = '0;
        i_rst_n    = 1'b0;
        stim_done  = 1'b0;
        drain_mode = 1'b0;
        err_count  = 0;
        tbl_used   = 0;
        stamp_next = 64'd1;
        evictions  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, id zero, extremes, then each kind on a live entry
        add_row(K_LOOKUP,  64'd5,   '0,      1, mk(S_NOTFOUND, 0, 0));
        add_row(K_TOUCH,   64'd5,   '0,      1, mk(S_NOTFOUND, 0, 0));
        add_row(K_OBSERVE, '0,      AllOnes, 1, mk(S_REJECTED, 0, 0));
        add_row(K_CREATE,  '0,      '0,      1, mk(S_REJECTED, 0, 0));
        add_row(K_LOOKUP,  '0,      '0,      1, mk(S_NOTFOUND, 0, 0));
        add_row(K_OBSERVE, AllOnes, AllOnes, 1, mk(S_DONE, 0, AllOnes));
        add_row(K_OBSERVE, AllOnes, 64'd3,   1, mk(S_DONE, 0, AllOnes));
        add_row(K_CREATE,  AllOnes, '0,      1, mk(S_REJECTED, 0, 0));
        add_row(K_CREATE,  64'd1,   AllOnes, 1, mk(S_DONE, 1, 0));
        add_row(K_OBSERVE, 64'd1,   64'd7,   1, mk(S_DONE, 1, 64'd7));
        add_row(K_OBSERVE, 64'd1,   64'd2,   1, mk(S_DONE, 1, 64'd7));
        add_row(K_LOOKUP,  64'd1,   '0,      1, mk(S_DONE, 1, 64'd7));
        add_row(K_TOUCH,   AllOnes, '0,      1, mk(S_DONE, 0, AllOnes));
        add_row(K_CREATE,  64'h8000_0000_0000_0000, '0, 0, '0);
        add_row(K_OBSERVE, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0, '0);
        add_row(K_OBSERVE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 0, '0);
        add_row(K_LOOKUP,  64'h5555_5555_5555_5555, '0, 0, '0);
        add_row(K_TOUCH,   64'h8000_0000_0000_0000, '0, 0, '0);
        foreach (rows[i]) begin
            send_one(rows[i].kind, rows[i].sid, rows[i].cseq, rows[i].typed, rows[i].want);
            idle_gap();
        end

        // random part: fill past capacity so evictions come up
        for (int n = 0; n < NumRand; n++) begin
            if (n == 300) begin
                // sender pause until every response is back
                req_ch.valid <= 1'b0;
                while (pending_rsp.size() != 0) @(posedge i_clk);
            end
            drain_mode = (n >= 600 && n < 640);
            k = t_kind'($urandom_range(0, 3));
            if ($urandom_range(0, 2) == 0) k = K_OBSERVE;
            send_one(k, pick_id(), pick_seq(), 0, '0);
            idle_gap();
        end
        req_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // ---- response side ----
    int stall_left;
    bit long_done;          // the long hold-off has been taken

    initial begin
        rsp_ch.ready = 1'b0;
        stall_left   = 0;
        long_done    = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (drain_mode && !long_done && stall_left == 0) begin
                // long hold-off while requests keep coming: fills the queue
                stall_left = 400;
                long_done  = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (rsp_ch.ready && rsp_ch.valid) begin
                // accepted this edge; draw the gap before the next response
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ---- checker and watchdog ----
    int quiet;

    always @(posedge i_clk) begin
        t_rsp w;
        if (!i_rst_n) begin
            quiet <= 0;
        end else begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_rsp.size() == 0) begin
                    report_mismatch("unexpected response", 64'(rsp_ch.status), '0);
                end else begin
                    w = pending_rsp.pop_front();
                    if (rsp_ch.status != w.status)
                        report_mismatch("status", 64'(rsp_ch.status), 64'(w.status));
                    if (rsp_ch.slot != w.slot)
                        report_mismatch("slot", 64'(rsp_ch.slot), 64'(w.slot));
                    if (rsp_ch.last_seq != w.last_seq)
                        report_mismatch("last_seq", rsp_ch.last_seq, w.last_seq);
                    if (rsp_ch.did_evict != w.did_evict)
                        report_mismatch("did_evict", 64'(rsp_ch.did_evict),
                                        64'(w.did_evict));
                    if (rsp_ch.evict_total != w.evict_total)
                        report_mismatch("evict_total", 64'(rsp_ch.evict_total),
                                        64'(w.evict_total));
                end
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        while (!(stim_done && pending_rsp.size() == 0)) begin
            @(posedge i_clk);
            if (quiet >= WdogMax) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
        // let any stray response show up
        repeat (200) @(posedge i_clk);
        if (err_count == 0 && pending_rsp.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
